[rtl/mnep_pkg.sv]
// shared types and constants for the midi note event parser
package mnep_pkg;

   localparam int unsigned BYTE_WIDTH      = 8;
   localparam int unsigned KIND_WIDTH      = 2;
   localparam int unsigned CHANNEL_WIDTH   = 4;
   localparam int unsigned NOTE_WIDTH      = 7;
   localparam int unsigned VELOCITY_WIDTH  = 7;
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 1;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_NONE    = 2'd0,
      KIND_NOTE_ON = 2'd1,
      KIND_NOTE_OFF = 2'd2,
      KIND_FORWARD = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      HELD_NONE   = 2'd0,
      HELD_STATUS = 2'd1,
      HELD_NOTE   = 2'd2
   } held_type;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FORWARD_OTHER = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FORWARD_SYSEX = 1'd1;

   localparam logic [3:0] HI_NOTE_OFF = 4'h8;
   localparam logic [3:0] HI_NOTE_ON  = 4'h9;
   localparam logic [3:0] HI_SYSTEM   = 4'hF;
   localparam logic [BYTE_WIDTH-1:0] SYSEX_START = 8'hF0;

endpackage

[rtl/midi_note_event_parser.sv]
// midi note event parser: running status note-on/note-off extraction
//
// usage
//   req channel: one received midi byte per transaction on req_rx_byte
//   rsp channel: exactly one result transaction per request transaction;
//     kind none, note on, note off or forwarded byte, unused fields zero
//   csr port: write-only, index 0 forward-other enable, index 1 forward-sysex
//     enable, only data bit 0 used; write only while the block is idle
//   latency: the result appears one cycle after the request is accepted
//   throughput: one byte per cycle, set by the single result register
//   a new request is taken while a result waits, as long as rsp is not stalled
//   a stall on rsp holds the result and stalls req in the same cycle
//   reset clears running status, held bytes, the sysex mark, both enables
//   and the result valid
module midi_note_event_parser (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [mnep_pkg::BYTE_WIDTH-1:0]        req_rx_byte,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [mnep_pkg::KIND_WIDTH-1:0]        rsp_result_kind,
   output logic [mnep_pkg::CHANNEL_WIDTH-1:0]     rsp_event_channel,
   output logic [mnep_pkg::NOTE_WIDTH-1:0]        rsp_event_note,
   output logic [mnep_pkg::VELOCITY_WIDTH-1:0]    rsp_event_velocity,
   output logic [mnep_pkg::BYTE_WIDTH-1:0]        rsp_forward_byte,
   input  logic                                   csr_write_enable,
   input  logic [mnep_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [mnep_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);
   import mnep_pkg::*;

   logic                       fwd_other_ff;
   logic                       fwd_sysex_ff;
   logic                       running_on_ff, running_on_in;
   logic [CHANNEL_WIDTH-1:0]   channel_ff, channel_in;
   logic [NOTE_WIDTH-1:0]      note_ff, note_in;
   held_type                   held_ff, held_in;
   logic                       in_sysex_ff, in_sysex_in;

   logic                       rsp_valid_ff;
   kind_type                   kind_ff, kind_in;
   logic [CHANNEL_WIDTH-1:0]   ev_channel_ff, ev_channel_in;
   logic [NOTE_WIDTH-1:0]      ev_note_ff, ev_note_in;
   logic [VELOCITY_WIDTH-1:0]  ev_velocity_ff, ev_velocity_in;
   logic [BYTE_WIDTH-1:0]      fwd_byte_ff, fwd_byte_in;

   logic                       req_accept;
   logic [3:0]                 hi_nibble;
   logic [VELOCITY_WIDTH-1:0]  velocity;
   logic                       fwd_enable;
   logic                       fwd_request;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign hi_nibble  = req_rx_byte[BYTE_WIDTH-1 -: 4];
   assign velocity   = req_rx_byte[VELOCITY_WIDTH-1:0];

   always_comb begin
      running_on_in  = running_on_ff;
      channel_in     = channel_ff;
      note_in        = note_ff;
      held_in        = held_ff;
      in_sysex_in    = in_sysex_ff;
      kind_in        = KIND_NONE;
      ev_channel_in  = '0;
      ev_note_in     = '0;
      ev_velocity_in = '0;
      fwd_request    = 1'b0;
      fwd_enable     = 1'b0;

      if (req_rx_byte[BYTE_WIDTH-1]) begin
         priority if (hi_nibble == HI_NOTE_OFF || hi_nibble == HI_NOTE_ON) begin
            running_on_in = (hi_nibble == HI_NOTE_ON);
            channel_in    = req_rx_byte[CHANNEL_WIDTH-1:0];
            held_in       = HELD_STATUS;
         end else if (hi_nibble != HI_SYSTEM) begin
            held_in     = HELD_NONE;
            fwd_request = 1'b1;
            fwd_enable  = fwd_other_ff;
         end else if (!req_rx_byte[3]) begin
            // system common clears running status
            held_in     = HELD_NONE;
            in_sysex_in = (req_rx_byte == SYSEX_START);
            fwd_request = 1'b1;
            fwd_enable  = (req_rx_byte == SYSEX_START) ? fwd_sysex_ff : fwd_other_ff;
         end else begin
            // realtime
            fwd_request = 1'b1;
            fwd_enable  = fwd_other_ff;
         end
      end else begin
         unique case (held_ff)
            HELD_STATUS: begin
               note_in = req_rx_byte[NOTE_WIDTH-1:0];
               held_in = HELD_NOTE;
            end
            HELD_NOTE: begin
               kind_in        = (running_on_ff && velocity != '0) ? KIND_NOTE_ON
                                                                  : KIND_NOTE_OFF;
               ev_channel_in  = channel_ff;
               ev_note_in     = note_ff;
               ev_velocity_in = velocity;
               held_in        = HELD_STATUS;
            end
            default: begin
               // stray data byte
               fwd_request = 1'b1;
               fwd_enable  = in_sysex_ff ? fwd_sysex_ff : fwd_other_ff;
            end
         endcase
      end

      fwd_byte_in = '0;
      if (fwd_request && fwd_enable) begin
         kind_in     = KIND_FORWARD;
         fwd_byte_in = req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_other_ff <= 1'b0;
         fwd_sysex_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FORWARD_OTHER: fwd_other_ff <= csr_write_data[0];
            CSR_FORWARD_SYSEX: fwd_sysex_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_on_ff <= 1'b0;
         channel_ff    <= '0;
         note_ff       <= '0;
         held_ff       <= HELD_NONE;
         in_sysex_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (req_accept) begin
         running_on_ff <= running_on_in;
         channel_ff    <= channel_in;
         note_ff       <= note_in;
         held_ff       <= held_in;
         in_sysex_ff   <= in_sysex_in;
         rsp_valid_ff  <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff        <= kind_in;
         ev_channel_ff  <= ev_channel_in;
         ev_note_ff     <= ev_note_in;
         ev_velocity_ff <= ev_velocity_in;
         fwd_byte_ff    <= fwd_byte_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_event_channel  = ev_channel_ff;
   assign rsp_event_note     = ev_note_ff;
   assign rsp_event_velocity = ev_velocity_ff;
   assign rsp_forward_byte   = fwd_byte_ff;

endmodule

[verif/midi_note_event_parser_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for the midi note event parser with running status
module midi_note_event_parser_tb;
   import mnep_pkg::*;

   localparam logic [BYTE_WIDTH-1:0] COMMON_LAST = 8'hF7;
   localparam int unsigned RANDOM_BYTES_PER_PHASE = 120;
   localparam int unsigned HOLD_AFTER_RESULTS = 330;
   localparam int unsigned HOLD_CYCLES = 60;

   typedef struct packed {
      kind_type                  kind;
      logic [CHANNEL_WIDTH-1:0]  channel;
      logic [NOTE_WIDTH-1:0]     note;
      logic [VELOCITY_WIDTH-1:0] velocity;
      logic [BYTE_WIDTH-1:0]     fwd;
   } midi_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [BYTE_WIDTH-1:0] req_rx_byte = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [KIND_WIDTH-1:0] rsp_result_kind;
   logic [CHANNEL_WIDTH-1:0] rsp_event_channel;
   logic [NOTE_WIDTH-1:0] rsp_event_note;
   logic [VELOCITY_WIDTH-1:0] rsp_event_velocity;
   logic [BYTE_WIDTH-1:0] rsp_forward_byte;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_write_data = '0;

   logic [BYTE_WIDTH-1:0] midi_bytes_to_send[$];
   midi_event_type expected_events[$];

   // parser model state and enables
   logic forward_other_on = 1'b0;
   logic forward_sysex_on = 1'b0;
   kind_type running_kind = KIND_NONE;
   held_type held_stage = HELD_NONE;
   logic [CHANNEL_WIDTH-1:0] held_channel = '0;
   logic [NOTE_WIDTH-1:0] held_note = '0;
   logic in_sysex = 1'b0;

   int unsigned sender_idle_pct = 31;
   int unsigned receiver_idle_pct = 31;
   int unsigned hold_left = 0;
   logic hold_done = 1'b0;
   int unsigned bytes_queued = 0;
   int unsigned bytes_accepted = 0;
   int unsigned results_seen = 0;
   int unsigned kind_seen[4] = '{default: 0};
   int unsigned settings_run = 0;
   int unsigned failures = 0;

   midi_note_event_parser dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_event_channel  (rsp_event_channel),
      .rsp_event_note     (rsp_event_note),
      .rsp_event_velocity (rsp_event_velocity),
      .rsp_forward_byte   (rsp_forward_byte),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic midi_event_type parse_midi_byte(input logic [BYTE_WIDTH-1:0] rx);
      midi_event_type ev;
      logic [3:0] hi;
      logic fwd_en;
      logic do_fwd;
      ev = '0;
      ev.kind = KIND_NONE;
      hi = rx[7:4];
      fwd_en = 1'b0;
      do_fwd = 1'b0;
      if (rx[7]) begin
         if (hi == HI_NOTE_OFF || hi == HI_NOTE_ON) begin
            running_kind = (hi == HI_NOTE_ON) ? KIND_NOTE_ON : KIND_NOTE_OFF;
            held_channel = rx[3:0];
            held_stage = HELD_STATUS;
         end else if (hi != HI_SYSTEM) begin
            running_kind = KIND_NONE;
            held_stage = HELD_NONE;
            do_fwd = 1'b1;
            fwd_en = forward_other_on;
         end else if (rx <= COMMON_LAST) begin
            running_kind = KIND_NONE;
            held_stage = HELD_NONE;
            in_sysex = (rx == SYSEX_START);
            do_fwd = 1'b1;
            fwd_en = in_sysex ? forward_sysex_on : forward_other_on;
         end else begin
            do_fwd = 1'b1;
            fwd_en = forward_other_on;
         end
      end else if (held_stage == HELD_NONE) begin
         do_fwd = 1'b1;
         fwd_en = in_sysex ? forward_sysex_on : forward_other_on;
      end else if (held_stage == HELD_STATUS) begin
         held_note = rx[6:0];
         held_stage = HELD_NOTE;
      end else begin
         ev.kind = (running_kind == KIND_NOTE_ON && rx[6:0] != '0) ? KIND_NOTE_ON
                                                                  : KIND_NOTE_OFF;
         ev.channel = held_channel;
         ev.note = held_note;
         ev.velocity = rx[6:0];
         held_stage = HELD_STATUS;
      end
      if (do_fwd && fwd_en) begin
         ev.kind = KIND_FORWARD;
         ev.fwd = rx;
      end
      return ev;
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (midi_bytes_to_send.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_rx_byte <= midi_bytes_to_send.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // check results, then predict for the newly accepted byte
   always @(posedge clock) begin
      midi_event_type exp_ev;
      if (reset) begin
         running_kind = KIND_NONE;
         held_stage = HELD_NONE;
         held_channel = '0;
         held_note = '0;
         in_sysex = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            kind_seen[rsp_result_kind] <= kind_seen[rsp_result_kind] + 1;
            if (expected_events.size() == 0) begin
               $error("result transaction with nothing expected, kind %0d", rsp_result_kind);
               failures++;
            end else begin
               exp_ev = expected_events.pop_front();
               if (rsp_result_kind !== exp_ev.kind) begin
                  $error("result_kind expected %0d got %0d", exp_ev.kind, rsp_result_kind);
                  failures++;
               end
               if (rsp_event_channel !== exp_ev.channel) begin
                  $error("event_channel expected %0d got %0d", exp_ev.channel,
                         rsp_event_channel);
                  failures++;
               end
               if (rsp_event_note !== exp_ev.note) begin
                  $error("event_note expected %0d got %0d", exp_ev.note, rsp_event_note);
                  failures++;
               end
               if (rsp_event_velocity !== exp_ev.velocity) begin
                  $error("event_velocity expected %0d got %0d", exp_ev.velocity,
                         rsp_event_velocity);
                  failures++;
               end
               if (rsp_forward_byte !== exp_ev.fwd) begin
                  $error("forward_byte expected %02h got %02h", exp_ev.fwd, rsp_forward_byte);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            bytes_accepted <= bytes_accepted + 1;
            expected_events.push_back(parse_midi_byte(req_rx_byte));
         end
      end
   end

   task automatic queue_byte(input logic [BYTE_WIDTH-1:0] rx);
      midi_bytes_to_send.push_back(rx);
      bytes_queued++;
   endtask

   function automatic logic [BYTE_WIDTH-1:0] data_byte();
      return BYTE_WIDTH'($urandom_range(127));
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] realtime_byte();
      return BYTE_WIDTH'($urandom_range(8'hFF, 8'hF8));
   endfunction

   task automatic queue_random_traffic(input int unsigned count);
      int unsigned start;
      start = bytes_queued;
      while (bytes_queued - start < count) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
               queue_byte({3'b100, 1'($urandom_range(1)), 4'($urandom_range(15))});
               repeat ($urandom_range(5, 1)) begin
                  if ($urandom_range(7) == 0)
                     queue_byte(realtime_byte());
                  queue_byte(data_byte());
                  if ($urandom_range(9) != 0)
                     queue_byte(($urandom_range(3) == 0) ? 8'h00 : data_byte());
               end
            end
            6: begin
               queue_byte(SYSEX_START);
               repeat ($urandom_range(4)) queue_byte(data_byte());
               if ($urandom_range(3) == 0) begin
                  queue_byte({3'b100, 1'($urandom_range(1)), 4'($urandom_range(15))});
                  queue_byte(data_byte());
                  queue_byte(data_byte());
               end
               case ($urandom_range(3))
                  0, 1: queue_byte(COMMON_LAST);
                  2: queue_byte(BYTE_WIDTH'($urandom_range(8'hF6, 8'hF1)));
                  default: ;
               endcase
            end
            7: begin
               queue_byte(BYTE_WIDTH'($urandom_range(8'hEF, 8'hA0)));
               repeat ($urandom_range(2, 1)) queue_byte(data_byte());
            end
            8: queue_byte(realtime_byte());
            default: queue_byte(BYTE_WIDTH'($urandom));
         endcase
      end
   endtask

   task automatic wait_until_drained();
      while (midi_bytes_to_send.size() != 0 || req_valid || expected_events.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_enables(input logic other_en, input logic sysex_en);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_FORWARD_OTHER;
      csr_write_data <= other_en;
      @(posedge clock);
      csr_index <= CSR_FORWARD_SYSEX;
      csr_write_data <= sysex_en;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      forward_other_on = other_en;
      forward_sysex_on = sysex_en;
      settings_run++;
   endtask

   initial begin
      logic [BYTE_WIDTH-1:0] directed[$];
      directed = '{8'h90, 8'h00, 8'h7F, 8'h7F, 8'h00, 8'h8F, 8'h7F, 8'h40, 8'hA0,
                   8'h05, 8'hF0, 8'h12, 8'h9F, 8'h3C, 8'h64, 8'hF7, 8'hF8, 8'hFF,
                   8'h9A, 8'h11, 8'hF8, 8'h22, 8'hE5, 8'hF1, 8'h7F};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      write_enables(1'b1, 1'b1);
      foreach (directed[i]) queue_byte(directed[i]);
      queue_random_traffic(RANDOM_BYTES_PER_PHASE);
      wait_until_drained();

      // no idling on either side for this stretch
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      write_enables(1'b0, 1'b0);
      queue_random_traffic(RANDOM_BYTES_PER_PHASE);
      wait_until_drained();
      sender_idle_pct = 31;
      receiver_idle_pct = 31;

      write_enables(1'b1, 1'b0);
      queue_random_traffic(RANDOM_BYTES_PER_PHASE);
      wait_until_drained();

      write_enables(1'b0, 1'b1);
      queue_random_traffic(RANDOM_BYTES_PER_PHASE);
      wait_until_drained();

      $display("%0d midi bytes accepted under %0d enable settings, %0d results checked",
               bytes_accepted, settings_run, results_seen);
      $display("results: %0d none, %0d note on, %0d note off, %0d forwarded",
               kind_seen[KIND_NONE], kind_seen[KIND_NOTE_ON], kind_seen[KIND_NOTE_OFF],
               kind_seen[KIND_FORWARD]);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d results still expected", expected_events.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
